// ----- rtl/core/brps_pkg.sv -----
`timescale 1ns / 1ps

package brps_pkg;

    localparam int TICK_BITS_DEF = 16;
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int PHASE_BITS    = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_ACTIVE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BETWEEN       = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_ACTIVE = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLING      = 2'd3;

    localparam logic [PHASE_BITS-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_FIRST   = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_BETWEEN = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_SECOND  = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_SETTLE  = 3'd4;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef struct packed {
        logic func;
        logic close_first;
    } in_item_t;

    typedef struct packed {
        logic                  gates_closed;
        logic                  polarity_closed;
        logic [PHASE_BITS-1:0] phase;
        logic                  rejected;
    } out_item_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] first_active_ticks;
        logic [CFG_WIDTH-1:0] between_ticks;
        logic [CFG_WIDTH-1:0] second_active_ticks;
        logic [CFG_WIDTH-1:0] settling_ticks;
    } cfg_t;

endpackage

// ----- rtl/core/brps_cfg_regs.sv -----
`timescale 1ns / 1ps

module brps_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [brps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [brps_pkg::CFG_WIDTH-1:0]     cfg_wdata,
    output brps_pkg::cfg_t                     cfg
);

    brps_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                brps_pkg::CFG_FIRST_ACTIVE:  cfg_reg.first_active_ticks  <= cfg_wdata;
                brps_pkg::CFG_BETWEEN:       cfg_reg.between_ticks       <= cfg_wdata;
                brps_pkg::CFG_SECOND_ACTIVE: cfg_reg.second_active_ticks <= cfg_wdata;
                brps_pkg::CFG_SETTLING:      cfg_reg.settling_ticks      <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/brps_seq.sv -----
`timescale 1ns / 1ps

module brps_seq #(
    parameter int TICK_BITS = brps_pkg::TICK_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  brps_pkg::in_item_t  item,
    input  brps_pkg::cfg_t      cfg,
    output brps_pkg::out_item_t result
);

    localparam logic [63:0] CNT_MAX = (64'd1 << TICK_BITS) - 64'd1;

    logic [brps_pkg::PHASE_BITS-1:0] phase_reg, phase_next;
    logic [TICK_BITS-1:0]            remaining_reg, remaining_next;
    logic                            first_level_reg, first_level_next;
    logic                            gate_reg, gate_next;
    logic                            polarity_reg, polarity_next;
    logic                            rejected_next;

    function automatic logic [TICK_BITS-1:0] load_count(input logic [brps_pkg::CFG_WIDTH-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        if (wide > CNT_MAX) begin
            load_count = CNT_MAX[TICK_BITS-1:0];
        end else begin
            load_count = wide[TICK_BITS-1:0];
        end
    endfunction

    always_comb begin
        phase_next       = phase_reg;
        remaining_next   = remaining_reg;
        first_level_next = first_level_reg;
        gate_next        = gate_reg;
        polarity_next    = polarity_reg;
        rejected_next    = 1'b0;

        if (item.func == brps_pkg::FUNC_START) begin
            if (phase_reg != brps_pkg::PH_IDLE) begin
                rejected_next = 1'b1;
            end else begin
                first_level_next = item.close_first;
                polarity_next    = item.close_first;
                gate_next        = 1'b1;
                phase_next       = brps_pkg::PH_FIRST;
                remaining_next   = load_count(cfg.first_active_ticks);
            end
        end else if (phase_reg != brps_pkg::PH_IDLE) begin
            if (remaining_reg != '0) begin
                remaining_next = remaining_reg - TICK_BITS'(1);
            end
        end

        // pass zero-length phases, at most four in one item
        for (int i = 0; i < 4; i++) begin
            if (phase_next != brps_pkg::PH_IDLE && remaining_next == '0) begin
                case (phase_next)
                    brps_pkg::PH_FIRST: begin
                        gate_next      = 1'b0;
                        phase_next     = brps_pkg::PH_BETWEEN;
                        remaining_next = load_count(cfg.between_ticks);
                    end
                    brps_pkg::PH_BETWEEN: begin
                        polarity_next  = ~first_level_next;
                        gate_next      = 1'b1;
                        phase_next     = brps_pkg::PH_SECOND;
                        remaining_next = load_count(cfg.second_active_ticks);
                    end
                    brps_pkg::PH_SECOND: begin
                        gate_next      = 1'b0;
                        phase_next     = brps_pkg::PH_SETTLE;
                        remaining_next = load_count(cfg.settling_ticks);
                    end
                    default: begin
                        gate_next      = 1'b0;
                        phase_next     = brps_pkg::PH_IDLE;
                        remaining_next = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= brps_pkg::PH_IDLE;
            remaining_reg   <= '0;
            first_level_reg <= 1'b0;
            gate_reg        <= 1'b0;
            polarity_reg    <= 1'b0;
        end else if (accept) begin
            phase_reg       <= phase_next;
            remaining_reg   <= remaining_next;
            first_level_reg <= first_level_next;
            gate_reg        <= gate_next;
            polarity_reg    <= polarity_next;
        end
    end

    assign result.gates_closed    = gate_next;
    assign result.polarity_closed = polarity_next;
    assign result.phase           = phase_next;
    assign result.rejected        = rejected_next;

endmodule

// ----- rtl/core/bipolar_relay_pulse_sequencer_top.sv -----
`timescale 1ns / 1ps

// Bipolar relay pulse sequencer. Each input item is either a one-millisecond
// tick or a start command; every item yields exactly one result with the gate
// and polarity relay drives, the current phase and a flag for a command
// refused while a pulse is in progress. An item is taken every cycle as long
// as the result register is empty or being drained, so the throughput is one
// item per cycle; each result is registered for the next cycle. The phase
// machine with its single down-counter finishes each item in one pass, including
// any run of zero-length phases. Phase lengths are read from the configuration
// registers when a phase is loaded and saturate at the counter width TICK_BITS.

module bipolar_relay_pulse_sequencer_top #(
    parameter int TICK_BITS = brps_pkg::TICK_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [brps_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [brps_pkg::CFG_WIDTH-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  brps_pkg::in_item_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output brps_pkg::out_item_t                m_data
);

    brps_pkg::cfg_t      cfg;
    brps_pkg::out_item_t result;
    brps_pkg::out_item_t m_data_reg;
    logic                m_valid_reg;
    logic                accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    brps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    brps_seq #(
        .TICK_BITS (TICK_BITS)
    ) u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- dv/brps_checker.sv -----
`timescale 1ns / 1ps

module brps_checker #(
    parameter int TICK_BITS = brps_pkg::TICK_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [brps_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [brps_pkg::CFG_WIDTH-1:0]    cfg_wdata,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  brps_pkg::in_item_t                s_data,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  brps_pkg::out_item_t               m_data,
    output int                                fail_count,
    output int                                pending
);
    import brps_pkg::*;

    cfg_t                  cfg_shadow;
    logic [PHASE_BITS-1:0] pulse_phase;
    logic [TICK_BITS-1:0]  ticks_left;
    logic                  first_pol;
    logic                  gate_on;
    logic                  pol_on;
    out_item_t             expected_drive_q[$];

    function automatic logic [TICK_BITS-1:0] load_span(logic [CFG_WIDTH-1:0] v);
        longint unsigned cmax;
        longint unsigned vv;
        logic [TICK_BITS-1:0] r;
        cmax = (64'd1 << TICK_BITS) - 64'd1;
        vv = 64'(v);
        if (vv > cmax) begin
            vv = cmax;
        end
        r = vv[TICK_BITS-1:0];
        return r;
    endfunction

    function automatic void next_phase();
        case (pulse_phase)
            PH_FIRST: begin
                gate_on     = 1'b0;
                pulse_phase = PH_BETWEEN;
                ticks_left  = load_span(cfg_shadow.between_ticks);
            end
            PH_BETWEEN: begin
                pol_on      = ~first_pol;
                gate_on     = 1'b1;
                pulse_phase = PH_SECOND;
                ticks_left  = load_span(cfg_shadow.second_active_ticks);
            end
            PH_SECOND: begin
                gate_on     = 1'b0;
                pulse_phase = PH_SETTLE;
                ticks_left  = load_span(cfg_shadow.settling_ticks);
            end
            default: begin
                gate_on     = 1'b0;
                pulse_phase = PH_IDLE;
                ticks_left  = '0;
            end
        endcase
    endfunction

    function automatic out_item_t sequence_step(in_item_t it);
        out_item_t o;
        logic      refused;
        refused = 1'b0;
        if (it.func == FUNC_START) begin
            if (pulse_phase != PH_IDLE) begin
                refused = 1'b1;
            end else begin
                first_pol   = it.close_first;
                pol_on      = it.close_first;
                gate_on     = 1'b1;
                pulse_phase = PH_FIRST;
                ticks_left  = load_span(cfg_shadow.first_active_ticks);
            end
        end else if (pulse_phase != PH_IDLE && ticks_left != '0) begin
            ticks_left = ticks_left - TICK_BITS'(1);
        end
        // zero-length phases fall through within the same item
        while (pulse_phase != PH_IDLE && ticks_left == '0) begin
            next_phase();
        end
        o.gates_closed    = gate_on;
        o.polarity_closed = pol_on;
        o.phase           = pulse_phase;
        o.rejected        = refused;
        return o;
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            cfg_shadow  = '0;
            pulse_phase = PH_IDLE;
            ticks_left  = '0;
            first_pol   = 1'b0;
            gate_on     = 1'b0;
            pol_on      = 1'b0;
            expected_drive_q.delete();
            fail_count  = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FIRST_ACTIVE:  cfg_shadow.first_active_ticks  = cfg_wdata;
                    CFG_BETWEEN:       cfg_shadow.between_ticks       = cfg_wdata;
                    CFG_SECOND_ACTIVE: cfg_shadow.second_active_ticks = cfg_wdata;
                    CFG_SETTLING:      cfg_shadow.settling_ticks      = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_drive_q.size() == 0) begin
                    $error("result with nothing expected: %b", m_data);
                    fail_count++;
                end else begin
                    want = expected_drive_q.pop_front();
                    if (m_data.gates_closed !== want.gates_closed) begin
                        $error("gates_closed expected %0d, got %0d",
                               want.gates_closed, m_data.gates_closed);
                        fail_count++;
                    end
                    if (m_data.polarity_closed !== want.polarity_closed) begin
                        $error("polarity_closed expected %0d, got %0d",
                               want.polarity_closed, m_data.polarity_closed);
                        fail_count++;
                    end
                    if (m_data.phase !== want.phase) begin
                        $error("phase expected %0d, got %0d", want.phase, m_data.phase);
                        fail_count++;
                    end
                    if (m_data.rejected !== want.rejected) begin
                        $error("rejected expected %0d, got %0d",
                               want.rejected, m_data.rejected);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_drive_q.push_back(sequence_step(s_data));
            end
        end
        pending = expected_drive_q.size();
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import brps_pkg::*;

    localparam int TICK_W      = TICK_BITS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_SPAN   = 12;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_wr_en;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]    cfg_wdata;
    logic                    s_valid;
    logic                    s_ready;
    in_item_t                s_data;
    logic                    m_valid;
    logic                    m_ready;
    out_item_t               m_data;

    int fail_count;
    int pending;
    int cycle_count;
    int items_sent;
    int starts_sent;
    int settings_used;
    bit quiet;

    bipolar_relay_pulse_sequencer_top #(.TICK_BITS(TICK_W)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    brps_checker #(.TICK_BITS(TICK_W)) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    task automatic send_item(logic func, logic level);
        in_item_t it;
        it.func        = func;
        it.close_first = level;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        if (func == FUNC_START) begin
            starts_sent++;
        end
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
    endtask

    task automatic send_tick();
        send_item(FUNC_TICK, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        do begin
            while (pending != 0) @(posedge aclk);
            repeat (3) @(posedge aclk);
        end while (pending != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_WIDTH-1:0] val);
        wait_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(logic [CFG_WIDTH-1:0] fa, logic [CFG_WIDTH-1:0] bt,
                             logic [CFG_WIDTH-1:0] sa, logic [CFG_WIDTH-1:0] st);
        write_reg(CFG_FIRST_ACTIVE, fa);
        write_reg(CFG_BETWEEN, bt);
        write_reg(CFG_SECOND_ACTIVE, sa);
        write_reg(CFG_SETTLING, st);
        settings_used++;
    endtask

    function automatic logic [CFG_WIDTH-1:0] short_span();
        if ($urandom_range(0, 9) < 3) begin
            return '0;
        end
        return CFG_WIDTH'($urandom_range(1, 5));
    endfunction

    initial begin
        int round;
        int in_round;
        int n;
        quiet         = 1'b0;
        items_sent    = 0;
        starts_sent   = 0;
        settings_used = 1;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset spans are all zero: a start runs through every phase at once
        send_tick();
        send_item(FUNC_START, 1'b1);
        send_item(FUNC_START, 1'b0);
        send_tick();

        // between phase skipped, start while busy refused
        write_all(16'd2, 16'd0, 16'd1, 16'd1);
        send_item(FUNC_START, 1'b1);
        send_item(FUNC_START, 1'b0);
        repeat (4) send_tick();
        send_item(FUNC_START, 1'b0);
        repeat (4) send_tick();

        // empty first half goes straight to the gap
        write_all(16'd0, 16'd1, 16'd0, 16'd0);
        send_item(FUNC_START, 1'b0);
        send_item(FUNC_START, 1'b1);
        send_tick();
        send_tick();

        // longer spans, second half rewritten while the pulse runs
        quiet = 1'b1;
        write_all(CFG_WIDTH'(LONG_SPAN), 16'd0, 16'd0, 16'd0);
        send_item(FUNC_START, 1'b1);
        repeat (5) send_tick();
        write_reg(CFG_SECOND_ACTIVE, CFG_WIDTH'(LONG_SPAN));
        write_reg(CFG_SETTLING, 16'd2);
        settings_used++;
        send_item(FUNC_START, 1'b0);
        repeat (2 * LONG_SPAN) send_tick();
        send_item(FUNC_START, 1'b1);
        repeat (4) send_tick();
        quiet = 1'b0;

        for (round = 0; round < 8; round++) begin
            if (round == 7) begin
                quiet = 1'b1;
            end
            write_all(short_span(), short_span(), short_span(), short_span());
            in_round = 0;
            while (in_round < 48) begin
                n = $urandom_range(0, 9);
                if (n < 7) begin
                    send_item(FUNC_START, 1'($urandom_range(0, 1)));
                    in_round++;
                    n = $urandom_range(0, 24);
                    repeat (n) begin
                        if ($urandom_range(0, 9) == 0) begin
                            send_item(FUNC_START, 1'($urandom_range(0, 1)));
                            in_round++;
                        end
                        send_tick();
                        in_round++;
                    end
                end else if (n < 9) begin
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    in_round++;
                end else begin
                    write_reg(CFG_IDX_BITS'($urandom_range(0, 3)), short_span());
                    settings_used++;
                end
            end
        end

        wait_results();
        repeat (5) @(posedge aclk);
        $display("run covered %0d items, %0d of them start commands,", items_sent, starts_sent);
        $display("over %0d span settings with random stalls on both sides", settings_used);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
